### src/audio_pixel_correlation_mi_assert.svh
// Assertion macros, used by the window queue.
// Both macros expect a clock named clk and an active-low reset named rst_n.
`ifndef AUDIO_PIXEL_CORRELATION_MI_ASSERT_SVH
`define AUDIO_PIXEL_CORRELATION_MI_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APCMI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apcmi assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define APCMI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apcmi assertion failed");

`endif

### src/apcmi_pkg.sv
`timescale 1ns / 1ps
package apcmi_pkg;

  // Field widths.
  localparam int X_W   = 15;
  localparam int C_W   = 8;
  localparam int Y_W   = 16;
  localparam int COL_W = 10;
  localparam int MIX_W = 8;

  // Window sums, sized for windows of up to 127 pairs.
  localparam int N_W   = 7;
  localparam int SX_W  = 22;
  localparam int SXX_W = 37;
  localparam int SY_W  = 23;
  localparam int SYY_W = 39;
  localparam int SXY_W = 38;

  // Back-end arithmetic.
  localparam int MUL_W  = 64;
  localparam int PROD_W = 128;
  localparam int WIDE_W = 90;
  localparam int FRAC_N = 40;

  // Window queue.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [X_W-1:0] THR_RESET = 15'd300;
  localparam logic [MIX_W-1:0] MIX_MAX = 8'd255;

  // One closed window, handed from the front to the back.
  typedef struct packed {
    logic [N_W-1:0]   n;
    logic [SX_W-1:0]  sx;
    logic [SXX_W-1:0] sxx;
    logic [SY_W-1:0]  sy;
    logic [SYY_W-1:0] syy;
    logic [SXY_W-1:0] sxy;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
  } win_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  // Q8.8 luminance: 77 r + 150 g + 29 b.
  function automatic logic [Y_W-1:0] luma(input logic [C_W-1:0] r, input logic [C_W-1:0] g,
                                          input logic [C_W-1:0] b);
    luma = Y_W'(8'd77 * Y_W'(r)) + Y_W'(8'd150 * Y_W'(g)) + Y_W'(8'd29 * Y_W'(b));
  endfunction

endpackage

### src/apcmi_queue.sv
`timescale 1ns / 1ps
`include "audio_pixel_correlation_mi_assert.svh"
module apcmi_queue
  import apcmi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  win_t              din,
  input  logic              pop,
  output win_t              dout,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  win_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  // Pointer and fill count update.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Window storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

  `APCMI_ASSERT_IMP(a_no_overflow, push, cnt_r != QCNT_W'(QDEPTH))
  `APCMI_ASSERT_IMP(a_no_underflow, pop, cnt_r != '0)
  `APCMI_ASSERT_NXT(a_count_up, push && !pop, cnt_r == $past(cnt_r) + QCNT_W'(1))

endmodule

### src/apcmi_front.sv
`timescale 1ns / 1ps
module apcmi_front
  import apcmi_pkg::*;
#(
  parameter int MAX_SAMPLES = 32,
  parameter int COORD_BITS  = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [X_W-1:0]   rms,
  input  logic [C_W-1:0]   red,
  input  logic [C_W-1:0]   green,
  input  logic [C_W-1:0]   blue,
  input  logic [COL_W-1:0] col,
  input  logic [COL_W-1:0] row,
  input  logic             last,
  output logic             push,
  output win_t             rec,
  output logic [1:0]       pend
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int KEEP  = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
  localparam logic [COL_W-1:0] CMASK = COL_W'((1 << KEEP) - 1);

  // Stage 1: luminance.
  logic             s1_v_r, s1_last_r;
  logic [X_W-1:0]   s1_x_r;
  logic [Y_W-1:0]   s1_y_r;
  logic [COL_W-1:0] s1_col_r, s1_row_r;

  // Stage 2: products.
  logic               s2_v_r, s2_last_r;
  logic [X_W-1:0]     s2_x_r;
  logic [Y_W-1:0]     s2_y_r;
  logic [2*X_W-1:0]   s2_xx_r;
  logic [2*Y_W-1:0]   s2_yy_r;
  logic [X_W+Y_W-1:0] s2_xy_r;
  logic [COL_W-1:0]   s2_col_r, s2_row_r;

  // Stage 3: window sums.
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SX_W-1:0]  sx_r, sx_nxt;
  logic [SXX_W-1:0] sxx_r, sxx_nxt;
  logic [SY_W-1:0]  sy_r, sy_nxt;
  logic [SYY_W-1:0] syy_r, syy_nxt;
  logic [SXY_W-1:0] sxy_r, sxy_nxt;
  logic             take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r    <= rms;
    s1_y_r    <= luma(red, green, blue);
    s1_col_r  <= col;
    s1_row_r  <= row;
    s1_last_r <= last;
    s2_x_r    <= s1_x_r;
    s2_y_r    <= s1_y_r;
    s2_xx_r   <= s1_x_r * s1_x_r;
    s2_yy_r   <= s1_y_r * s1_y_r;
    s2_xy_r   <= s1_x_r * s1_y_r;
    s2_col_r  <= s1_col_r;
    s2_row_r  <= s1_row_r;
    s2_last_r <= s1_last_r;
  end

  // Accumulate while the window has room; a full window ignores the pair.
  always_comb begin
    take    = s2_v_r && (cnt_r < CNT_W'(MAX_SAMPLES));
    cnt_nxt = cnt_r;
    sx_nxt  = sx_r;
    sxx_nxt = sxx_r;
    sy_nxt  = sy_r;
    syy_nxt = syy_r;
    sxy_nxt = sxy_r;
    if (take) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      sx_nxt  = sx_r + SX_W'(s2_x_r);
      sxx_nxt = sxx_r + SXX_W'(s2_xx_r);
      sy_nxt  = sy_r + SY_W'(s2_y_r);
      syy_nxt = syy_r + SYY_W'(s2_yy_r);
      sxy_nxt = sxy_r + SXY_W'(s2_xy_r);
    end
  end

  assign push    = s2_v_r && s2_last_r;
  assign rec.n   = N_W'(cnt_nxt);
  assign rec.sx  = sx_nxt;
  assign rec.sxx = sxx_nxt;
  assign rec.sy  = sy_nxt;
  assign rec.syy = syy_nxt;
  assign rec.sxy = sxy_nxt;
  assign rec.col = s2_col_r & CMASK;
  assign rec.row = s2_row_r & CMASK;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sxx_r <= '0;
      sy_r  <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sx_r  <= sx_nxt;
      sxx_r <= sxx_nxt;
      sy_r  <= sy_nxt;
      syy_r <= syy_nxt;
      sxy_r <= sxy_nxt;
    end
  end

  // Closing pairs still in flight, each needing a queue slot.
  assign pend = 2'({1'b0, s1_v_r && s1_last_r}) + 2'({1'b0, s2_v_r && s2_last_r});

endmodule

### src/apcmi_mul.sv
`timescale 1ns / 1ps
module apcmi_mul
  import apcmi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int H_W = MUL_W / 2;

  logic              busy_r;
  logic [2:0]        ph_r;
  logic [MUL_W-1:0]  a_r, b_r;
  logic [MUL_W-1:0]  pp_r;
  logic [1:0]        sh_r;
  logic [PROD_W-1:0] acc_r;
  logic              done_r;
  logic [H_W-1:0]    a_sel, b_sel;

  // Pick the halves for the current partial product.
  assign a_sel = ph_r[1] ? a_r[MUL_W-1:H_W] : a_r[H_W-1:0];
  assign b_sel = ph_r[0] ? b_r[MUL_W-1:H_W] : b_r[H_W-1:0];

  // Control: four partial products, each added in the cycle after it is formed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        ph_r <= ph_r + 3'd1;
        if (ph_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (ph_r != 3'd4) begin
        pp_r <= a_sel * b_sel;
        sh_r <= 2'({1'b0, ph_r[1]}) + 2'({1'b0, ph_r[0]});
      end
      if (ph_r != 3'd0) begin
        acc_r <= acc_r + (PROD_W'(pp_r) << {sh_r, 5'b0});
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

### src/apcmi_back.sv
`timescale 1ns / 1ps
module apcmi_back
  import apcmi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [X_W-1:0]   thr,
  input  logic             q_empty,
  input  win_t             q_dout,
  output logic             q_pop,
  output mul_req_t         mreq,
  input  mul_rsp_t         mrsp,
  output logic             res_valid,
  input  logic             res_pop,
  output logic [MIX_W-1:0] res_mixel,
  output logic [X_W-1:0]   res_mean,
  output logic [COL_W-1:0] res_col,
  output logic [COL_W-1:0] res_row
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MEAN  = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_MGO   = 4'd3;
  localparam logic [3:0] S_MWAIT = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_CHK2  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_LOGI  = 4'd8;
  localparam logic [3:0] S_LGO   = 4'd9;
  localparam logic [3:0] S_LWAIT = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  localparam logic [2:0] M_NXY = 3'd0;
  localparam logic [2:0] M_XY  = 3'd1;
  localparam logic [2:0] M_NXX = 3'd2;
  localparam logic [2:0] M_XX  = 3'd3;
  localparam logic [2:0] M_NYY = 3'd4;
  localparam logic [2:0] M_YY  = 3'd5;
  localparam logic [2:0] M_P   = 3'd6;
  localparam logic [2:0] M_Q   = 3'd7;

  logic [3:0]        st_r;
  win_t              rec_r;
  logic [5:0]        cnt_r;
  logic [2:0]        mi_r;
  logic [SX_W-1:0]   mq_r;
  logic [N_W-1:0]    mrem_r;
  logic [MUL_W-1:0]  pa_r, axy_r, sxx_r, syy_r;
  logic              zero_r;
  logic [WIDE_W-1:0] p_r, q_r, d_r, rem_r;
  logic [MUL_W-1:0]  t_r, x_r;
  logic              lint_r;
  logic [FRAC_N-1:0] frac_r;
  logic [MIX_W-1:0]  mix_r;
  logic              start_r;
  logic              rv_r;
  logic [MIX_W-1:0]  rmix_r;
  logic [X_W-1:0]    rmean_r;
  logic [COL_W-1:0]  rcol_r, rrow_r;

  logic [N_W:0]       mtry;
  logic               mge;
  logic [MUL_W-1:0]   op_a, op_b;
  logic [MUL_W-1:0]   plo;
  logic [WIDE_W-1:0]  dv, rtry;
  logic               dge;
  logic [MUL_W-1:0]   xn;
  logic [FRAC_N:0]    lv;
  logic [FRAC_N+8:0]  lv255;

  // Mean: restoring division, one quotient bit a cycle.
  assign mtry = {mrem_r, rec_r.sx[cnt_r[4:0]]};
  assign mge  = (mtry >= {1'b0, rec_r.n});

  // Operand selection for the shared multiplier.
  always_comb begin
    case (mi_r)
      M_NXY:   begin op_a = MUL_W'(rec_r.n);  op_b = MUL_W'(rec_r.sxy); end
      M_XY:    begin op_a = MUL_W'(rec_r.sx); op_b = MUL_W'(rec_r.sy);  end
      M_NXX:   begin op_a = MUL_W'(rec_r.n);  op_b = MUL_W'(rec_r.sxx); end
      M_XX:    begin op_a = MUL_W'(rec_r.sx); op_b = MUL_W'(rec_r.sx);  end
      M_NYY:   begin op_a = MUL_W'(rec_r.n);  op_b = MUL_W'(rec_r.syy); end
      M_YY:    begin op_a = MUL_W'(rec_r.sy); op_b = MUL_W'(rec_r.sy);  end
      M_P:     begin op_a = axy_r;            op_b = axy_r;             end
      default: begin op_a = sxx_r;            op_b = syy_r;             end
    endcase
  end

  assign plo = mrsp.prod[MUL_W-1:0];

  // Quotient T = Q * 2^62 / D: the top bit uses 2D, the next uses D, later bits shift the remainder.
  assign dv   = (cnt_r == 6'd0) ? (d_r << 1) : d_r;
  assign rtry = (cnt_r >= 6'd2) ? (rem_r << 1) : rem_r;
  assign dge  = (rtry >= dv);

  // Log step: x = x^2 / 2^62.
  assign xn = mrsp.prod[MUL_W+61:62];

  // Scale the Q1.40 logarithm by 255, halve it and keep the integer part.
  assign lv    = {lint_r, frac_r};
  assign lv255 = {lv, 8'b0} - (FRAC_N + 9)'(lv);

  assign mreq.start = start_r;
  assign mreq.a     = (st_r == S_LWAIT) ? x_r : op_a;
  assign mreq.b     = (st_r == S_LWAIT) ? x_r : op_b;

  assign q_pop = (st_r == S_IDLE) && !q_empty;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            st_r <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (cnt_r == 6'd0) begin
            st_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (rec_r.n == '0 || mq_r < SX_W'(thr)) begin
            st_r <= S_OUT;
          end else begin
            st_r <= S_MGO;
          end
        end
        S_MGO: begin
          start_r <= 1'b1;
          st_r    <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mrsp.done) begin
            if (mi_r == M_Q) begin
              st_r <= S_CHK;
            end else if (mi_r == M_YY && (zero_r || pa_r <= plo)) begin
              st_r <= S_OUT;
            end else begin
              st_r <= S_MGO;
            end
          end
        end
        S_CHK: begin
          st_r <= (p_r >= q_r) ? S_OUT : S_CHK2;
        end
        S_CHK2: begin
          st_r <= (q_r >= (d_r << 2)) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          if (cnt_r == 6'd63) begin
            st_r <= S_LOGI;
          end
        end
        S_LOGI: begin
          st_r <= S_LGO;
        end
        S_LGO: begin
          start_r <= 1'b1;
          st_r    <= S_LWAIT;
        end
        S_LWAIT: begin
          if (mrsp.done) begin
            st_r <= (cnt_r == 6'(FRAC_N - 1)) ? S_FIN : S_LGO;
          end
        end
        S_FIN: begin
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (!rv_r) begin
            st_r <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        rec_r  <= q_dout;
        mrem_r <= '0;
        mq_r   <= '0;
        cnt_r  <= 6'(SX_W - 1);
        mix_r  <= '0;
        mi_r   <= M_NXY;
        zero_r <= 1'b0;
      end
      S_MEAN: begin
        mrem_r <= mge ? N_W'(mtry - {1'b0, rec_r.n}) : N_W'(mtry);
        mq_r   <= {mq_r[SX_W-2:0], mge};
        cnt_r  <= cnt_r - 6'd1;
      end
      S_MWAIT: begin
        if (mrsp.done) begin
          mi_r <= mi_r + 3'd1;
          case (mi_r)
            M_XY:    axy_r <= (pa_r >= plo) ? (pa_r - plo) : (plo - pa_r);
            M_XX: begin
              sxx_r  <= pa_r - plo;
              zero_r <= (pa_r <= plo);
            end
            M_YY:    syy_r <= pa_r - plo;
            M_P:     p_r   <= mrsp.prod[WIDE_W-1:0];
            M_Q:     q_r   <= mrsp.prod[WIDE_W-1:0];
            default: pa_r  <= plo;
          endcase
        end
      end
      S_CHK: begin
        d_r   <= q_r - p_r;
        mix_r <= (p_r >= q_r) ? MIX_MAX : '0;
      end
      S_CHK2: begin
        rem_r <= q_r;
        t_r   <= '0;
        cnt_r <= '0;
        if (q_r >= (d_r << 2)) begin
          mix_r <= MIX_MAX;
        end
      end
      S_DIV: begin
        rem_r <= dge ? (rtry - dv) : rtry;
        t_r   <= {t_r[MUL_W-2:0], dge};
        cnt_r <= cnt_r + 6'd1;
      end
      S_LOGI: begin
        lint_r <= t_r[MUL_W-1];
        x_r    <= t_r[MUL_W-1] ? (t_r >> 1) : t_r;
        frac_r <= '0;
        cnt_r  <= '0;
      end
      S_LWAIT: begin
        if (mrsp.done) begin
          frac_r <= {frac_r[FRAC_N-2:0], xn[MUL_W-1]};
          x_r    <= xn[MUL_W-1] ? (xn >> 1) : xn;
          cnt_r  <= cnt_r + 6'd1;
        end
      end
      S_FIN: begin
        mix_r <= lv255[FRAC_N+8:FRAC_N+1];
      end
      default: begin
      end
    endcase
  end

  // Result register: holds one result while the next window is worked on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else if (st_r == S_OUT && !rv_r) begin
      rv_r <= 1'b1;
    end else if (res_pop) begin
      rv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_OUT && !rv_r) begin
      rmix_r  <= mix_r;
      rmean_r <= mq_r[X_W-1:0];
      rcol_r  <= rec_r.col;
      rrow_r  <= rec_r.row;
    end
  end

  assign res_valid = rv_r;
  assign res_mixel = rmix_r;
  assign res_mean  = rmean_r;
  assign res_col   = rcol_r;
  assign res_row   = rrow_r;

endmodule

### src/audio_pixel_correlation_mi.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// input     in_push / in_full    in_rms, in_red, in_green, in_blue, in_pixel_col,
//                                in_pixel_row, in_last_sample
// result    out_pop / out_empty  out_mixel, out_rms_mean, out_col, out_row
// config    cfg_valid/cfg_ready  cfg_data (rms_threshold)
//
// The front takes one pair per cycle while in_full is low, through a three-stage accumulate pipeline.
// The back works out the mean of each window with a restoring divider, and when
// the sound is loud enough goes on to a 64-step divider and up to 48 passes through a
// shared multiplier that forms one 32x32 partial product a cycle.
// A four-entry window queue sits between them; in_full rises while closing pairs
// in flight would overfill it. Reset is synchronous and clears the sums.
module audio_pixel_correlation_mi
  import apcmi_pkg::*;
#(
  parameter int MAX_SAMPLES = 32,
  parameter int COORD_BITS  = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [X_W-1:0]   in_rms,
  input  logic [C_W-1:0]   in_red,
  input  logic [C_W-1:0]   in_green,
  input  logic [C_W-1:0]   in_blue,
  input  logic [COL_W-1:0] in_pixel_col,
  input  logic [COL_W-1:0] in_pixel_row,
  input  logic             in_last_sample,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [MIX_W-1:0] out_mixel,
  output logic [X_W-1:0]   out_rms_mean,
  output logic [COL_W-1:0] out_col,
  output logic [COL_W-1:0] out_row,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [X_W-1:0]   cfg_data
);

  logic [X_W-1:0]    thr_r;
  logic              f_push;
  win_t              f_rec;
  logic [1:0]        f_pend;
  logic              q_pop, q_empty;
  win_t              q_dout;
  logic [QCNT_W-1:0] q_count;
  mul_req_t          mreq;
  mul_rsp_t          mrsp;
  logic              res_valid;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  // Hold off input while closing pairs in flight could overfill the queue.
  assign in_full = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(f_pend)) >= (QCNT_W + 1)'(QDEPTH);

  apcmi_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (in_push && !in_full),
    .rms  (in_rms),
    .red  (in_red),
    .green(in_green),
    .blue (in_blue),
    .col  (in_pixel_col),
    .row  (in_pixel_row),
    .last (in_last_sample),
    .push (f_push),
    .rec  (f_rec),
    .pend (f_pend)
  );

  apcmi_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (f_push),
    .din  (f_rec),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty),
    .count(q_count)
  );

  apcmi_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .rsp  (mrsp)
  );

  apcmi_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .thr      (thr_r),
    .q_empty  (q_empty),
    .q_dout   (q_dout),
    .q_pop    (q_pop),
    .mreq     (mreq),
    .mrsp     (mrsp),
    .res_valid(res_valid),
    .res_pop  (out_pop && res_valid),
    .res_mixel(out_mixel),
    .res_mean (out_rms_mean),
    .res_col  (out_col),
    .res_row  (out_row)
  );

  assign out_empty = !res_valid;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import apcmi_pkg::*;

  // One result of the block as it appears on the result ports.
  typedef struct {
    logic [MIX_W-1:0] mixel;
    logic [X_W-1:0]   rms_mean;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
  } mixel_result_t;

  // Window accumulator and mixel predictor, with the queue of pending results.
  class mixel_scoreboard;
    localparam int MAX_PAIRS = 32;
    longint unsigned s_rms, s_rms_sq, s_luma, s_luma_sq, s_cross, count;
    logic [X_W-1:0]  threshold;
    mixel_result_t   pending[$];
    int              errors;

    function new();
      clear();
      threshold = THR_RESET;
      errors = 0;
    endfunction

    function void clear();
      s_rms = 0;
      s_rms_sq = 0;
      s_luma = 0;
      s_luma_sq = 0;
      s_cross = 0;
      count = 0;
    endfunction

    // Scaled -0.5*log2(1 - r^2), computed with exact integer steps.
    function logic [MIX_W-1:0] compute_mixel(longint unsigned n);
      longint          sxy, sxx, syy;
      logic [63:0]     axy, t, x, frac, lv;
      logic [127:0]    p, q, d, sq;
      logic [191:0]    num;
      sxy = longint'(n * s_cross) - longint'(s_rms * s_luma);
      sxx = longint'(n * s_rms_sq) - longint'(s_rms * s_rms);
      syy = longint'(n * s_luma_sq) - longint'(s_luma * s_luma);
      if (sxx <= 0 || syy <= 0) return 0;
      axy = (sxy < 0) ? 64'(-sxy) : 64'(sxy);
      p = 128'(axy) * 128'(axy);
      q = 128'(64'(sxx)) * 128'(64'(syy));
      if (p >= q) return MIX_MAX;
      d = q - p;
      if (q >= (d << 2)) return MIX_MAX;
      num = 192'(q) << 62;
      t = 64'(num / 192'(d));
      lv = 0;
      x = t;
      if (x[63]) begin
        lv = 1;
        x = x >> 1;
      end
      frac = 0;
      for (int i = 0; i < FRAC_N; i++) begin
        sq = 128'(x) * 128'(x);
        x = 64'(sq >> 62);
        frac = frac << 1;
        if (x[63]) begin
          frac[0] = 1'b1;
          x = x >> 1;
        end
      end
      lv = (lv << FRAC_N) | frac;
      lv = (64'd255 * lv) >> 41;
      return (lv > 255) ? MIX_MAX : lv[7:0];
    endfunction

    // Note one accepted pair; a closing pair queues the expected result.
    function void note_pair(logic [X_W-1:0] rms, logic [C_W-1:0] r, logic [C_W-1:0] g,
                            logic [C_W-1:0] b, logic [COL_W-1:0] col,
                            logic [COL_W-1:0] row, logic last);
      longint unsigned x, y, mean;
      mixel_result_t   res;
      x = 64'(rms);
      y = 64'(77 * r + 150 * g + 29 * b);
      if (count < MAX_PAIRS) begin
        s_rms += x;
        s_rms_sq += x * x;
        s_luma += y;
        s_luma_sq += y * y;
        s_cross += x * y;
        count++;
      end
      if (!last) return;
      mean = (count != 0) ? s_rms / count : 0;
      res.mixel = 0;
      if (count != 0 && mean >= threshold) res.mixel = compute_mixel(count);
      res.rms_mean = mean[X_W-1:0];
      res.col = col;
      res.row = row;
      pending.push_back(res);
      clear();
    endfunction

    // Compare one accepted result with the oldest pending one.
    function void check_result(mixel_result_t got);
      mixel_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: mixel %0d rms_mean %0d", got.mixel, got.rms_mean);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.mixel !== want.mixel) begin
        $error("mixel: expected %0d, actual %0d", want.mixel, got.mixel);
        errors++;
      end
      if (got.rms_mean !== want.rms_mean) begin
        $error("rms_mean: expected %0d, actual %0d", want.rms_mean, got.rms_mean);
        errors++;
      end
      if (got.col !== want.col) begin
        $error("out_col: expected %0d, actual %0d", want.col, got.col);
        errors++;
      end
      if (got.row !== want.row) begin
        $error("out_row: expected %0d, actual %0d", want.row, got.row);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic [X_W-1:0]   in_rms = '0;
  logic [C_W-1:0]   in_red = '0;
  logic [C_W-1:0]   in_green = '0;
  logic [C_W-1:0]   in_blue = '0;
  logic [COL_W-1:0] in_pixel_col = '0;
  logic [COL_W-1:0] in_pixel_row = '0;
  logic             in_last_sample = 1'b0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [MIX_W-1:0] out_mixel;
  logic [X_W-1:0]   out_rms_mean;
  logic [COL_W-1:0] out_col;
  logic [COL_W-1:0] out_row;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [X_W-1:0]   cfg_data = '0;

  mixel_scoreboard mixels = new();
  int              send_idle_pct = 0;
  int              pop_idle_pct = 0;
  int              pop_hold_cycles = 0;
  int              pairs_sent = 0;
  longint          cycle_count = 0;

  audio_pixel_correlation_mi dut (.*);

  always #6 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 5000000) begin
      $display("** audio_pixel_correlation_mi: FAILED **");
      $finish;
    end
  end

  // Result side: random pop gaps, an optional long hold, one check per transfer.
  initial begin
    mixel_result_t got;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        got.mixel = out_mixel;
        got.rms_mean = out_rms_mean;
        got.col = out_col;
        got.row = out_row;
        mixels.check_result(got);
      end
      if (pop_hold_cycles > 0) begin
        pop_hold_cycles--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_idle_pct);
      end
    end
  end

  // Offer one pair and wait for its transfer.
  task automatic send_pair(logic [X_W-1:0] rms, logic [C_W-1:0] r, logic [C_W-1:0] g,
                           logic [C_W-1:0] b, logic [COL_W-1:0] col,
                           logic [COL_W-1:0] row, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_rms <= rms;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_pixel_col <= col;
    in_pixel_row <= row;
    in_last_sample <= last;
    do @(posedge clk); while (in_full);
    mixels.note_pair(rms, r, g, b, col, row, last);
    pairs_sent++;
  endtask

  // Send one window. Style: 0 random, 1 correlated with noise, 2 flat color,
  // 3 perfectly correlated random gray, 4 anti-correlated, 5 constant sound.
  task automatic send_window(int len, int style);
    logic [COL_W-1:0] col, row;
    logic [C_W-1:0]   r, g, b, k;
    logic [X_W-1:0]   rms;
    int               noise, base, v;
    col = COL_W'($urandom);
    row = COL_W'($urandom);
    noise = $urandom_range(4000);
    base = $urandom_range(20000);
    for (int i = 0; i < len; i++) begin
      k = C_W'($urandom);
      r = C_W'($urandom);
      g = C_W'($urandom);
      b = C_W'($urandom);
      rms = X_W'($urandom);
      case (style)
        1: begin
          v = (77 * r + 150 * g + 29 * b) / 4 + $urandom_range(noise);
          rms = (v > 32767) ? 15'd32767 : v[14:0];
        end
        2: begin
          r = 8'd90;
          g = 8'd180;
          b = 8'd33;
        end
        3: begin
          r = k;
          g = k;
          b = k;
          rms = 15'(128 * k);
        end
        4: begin
          v = 32767 - (77 * r + 150 * g + 29 * b) / 2 + $urandom_range(noise);
          rms = (v > 32767) ? 15'd32767 : v[14:0];
        end
        5: rms = base[14:0];
        default: ;
      endcase
      send_pair(rms, r, g, b, col, row, i == len - 1);
    end
  endtask

  // Wait until every result has come back and the block has gone quiet.
  task automatic drain();
    in_push <= 1'b0;
    while (mixels.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_threshold(logic [X_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mixels.threshold = value;
  endtask

  task automatic random_windows(int pair_goal);
    int len;
    while (pairs_sent < pair_goal) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 20);
      send_window(len, ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 5));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed windows at the reset threshold, then with the threshold at zero.
    send_pair(15'd32767, 8'd255, 8'd255, 8'd255, 10'd1023, 10'd1023, 1'b1);
    send_pair(15'd0, 8'd0, 8'd0, 8'd0, 10'd0, 10'd0, 1'b1);
    send_pair(15'd299, 8'd0, 8'd0, 8'd0, 10'd5, 10'd6, 1'b0);
    send_pair(15'd300, 8'd255, 8'd255, 8'd255, 10'd5, 10'd6, 1'b1);
    drain();
    write_threshold(15'd0);
    send_window(4, 3);
    send_window(4, 4);
    send_window(3, 2);
    send_window(3, 5);
    send_window(5, 1);
    drain();

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 18;
    pop_idle_pct = 71;
    random_windows(500);
    drain();

    // Highest threshold: nearly every mixel is forced to zero.
    write_threshold(15'd32767);
    random_windows(600);
    drain();

    // Receiver idles lightly, sender heavily.
    write_threshold(15'($urandom_range(3000)));
    send_idle_pct = 71;
    pop_idle_pct = 18;
    random_windows(1100);
    drain();

    // No idling; a long receiver hold fills the block and stalls its input.
    write_threshold(15'd300);
    send_idle_pct = 0;
    pop_idle_pct = 0;
    pop_hold_cycles = 3000;
    random_windows(1650);
    drain();

    if (mixels.errors == 0 && mixels.pending.size() == 0) begin
      $display("** audio_pixel_correlation_mi: PASSED **");
    end else begin
      $display("** audio_pixel_correlation_mi: FAILED **");
    end
    $finish;
  end
endmodule
